>>> hw/rtl/address_breakpoint_pool_core_macros.svh
// Assertion macros used by the checker of the breakpoint pool.
`ifndef ADDRESS_BREAKPOINT_POOL_CORE_MACROS_SVH
`define ADDRESS_BREAKPOINT_POOL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/abp_pkg.sv
package abp_pkg;

    localparam int unsigned NUM_SLOTS  = 32;
    localparam int unsigned ADDR_WIDTH = 32;

    // Port field widths are fixed.
    localparam int unsigned OP_W    = 2;
    localparam int unsigned PADDR_W = 32;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned ERR_W   = 2;

    localparam int unsigned SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned COUNT_W    = $clog2(NUM_SLOTS + 1);

    localparam logic [COUNT_W-1:0] SLOT_COUNT = COUNT_W'(NUM_SLOTS);

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INACTIVE = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
        logic reduce;
        logic publish;
    } abp_cmd_t;

    typedef struct packed {
        logic is_scan;
    } abp_sts_t;

endpackage

>>> hw/rtl/abp_ctrl.sv
module abp_ctrl
    import abp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  abp_sts_t sts,
    output abp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = sts.is_scan ? ST_REDUCE : ST_DONE;
            end
            ST_REDUCE: begin
                cmd.reduce = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

>>> hw/rtl/abp_datapath.sv
module abp_datapath
    import abp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  abp_cmd_t           cmd,
    output abp_sts_t           sts,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [PADDR_W-1:0] s_address,
    input  logic [SLOT_W-1:0]  s_slot,
    output logic [SLOT_W-1:0]  m_slot_number,
    output logic               m_hit,
    output logic [ERR_W-1:0]   m_error_code
);

    // Captured request.
    logic [OP_W-1:0]       req_op_reg;
    logic [ADDR_WIDTH-1:0] req_addr_reg;
    logic [SLOT_W-1:0]     req_slot_reg;

    // Pool state.
    logic [ADDR_WIDTH-1:0] slot_address_reg  [NUM_SLOTS];
    logic [ADDR_WIDTH-1:0] slot_address_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  slot_active_reg;
    logic [NUM_SLOTS-1:0]  slot_active_next;
    logic [SLOT_IDX_W-1:0] free_stack_reg    [NUM_SLOTS];
    logic [SLOT_IDX_W-1:0] free_stack_next   [NUM_SLOTS];
    logic [COUNT_W-1:0]    free_count_reg;
    logic [COUNT_W-1:0]    free_count_next;

    // Per-slot match bits, reduced in the following cycle.
    logic [NUM_SLOTS-1:0]  match_reg;
    logic [NUM_SLOTS-1:0]  match_next;

    // Result of the current request, then the output register.
    logic [SLOT_W-1:0]     res_number_reg;
    logic [SLOT_W-1:0]     res_number_next;
    logic                  res_hit_reg;
    logic                  res_hit_next;
    logic [ERR_W-1:0]      res_err_reg;
    logic [ERR_W-1:0]      res_err_next;
    logic [SLOT_W-1:0]     out_number_reg;
    logic                  out_hit_reg;
    logic [ERR_W-1:0]      out_err_reg;

    logic [COUNT_W-1:0]    top_pos;
    logic [SLOT_IDX_W-1:0] pop_slot;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  add_ok;
    logic                  free_ok;

    assign sts.is_scan = (req_op_reg == OP_SCAN);

    assign top_pos  = free_count_reg - COUNT_W'(1);
    assign pop_slot = free_stack_reg[top_pos[SLOT_IDX_W-1:0]];
    assign free_idx = SLOT_IDX_W'(req_slot_reg);
    assign add_ok   = (free_count_reg != '0);
    assign free_ok  = (32'(req_slot_reg) < NUM_SLOTS) && slot_active_reg[free_idx]
                   && (free_count_reg < SLOT_COUNT);

    always_comb begin
        slot_address_next = slot_address_reg;
        slot_active_next  = slot_active_reg;
        free_stack_next   = free_stack_reg;
        free_count_next   = free_count_reg;
        res_number_next   = res_number_reg;
        res_hit_next      = res_hit_reg;
        res_err_next      = res_err_reg;

        for (int i = 0; i < NUM_SLOTS; i++) begin
            match_next[i] = slot_active_reg[i] && (slot_address_reg[i] == req_addr_reg);
        end

        if (cmd.execute) begin
            res_number_next = '0;
            res_hit_next    = 1'b0;
            res_err_next    = ERR_OK;
            case (req_op_reg)
                OP_ADD: begin
                    if (add_ok) begin
                        free_count_next             = top_pos;
                        slot_address_next[pop_slot] = req_addr_reg;
                        slot_active_next[pop_slot]  = 1'b1;
                        res_number_next             = SLOT_W'(pop_slot);
                    end else begin
                        res_err_next = ERR_FULL;
                    end
                end
                OP_FREE: begin
                    if (free_ok) begin
                        slot_active_next[free_idx] = 1'b0;
                        free_stack_next[free_count_reg[SLOT_IDX_W-1:0]] = free_idx;
                        free_count_next = free_count_reg + COUNT_W'(1);
                    end else begin
                        res_err_next = ERR_INACTIVE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.reduce) begin
            res_hit_next = |match_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_active_reg <= '0;
            free_count_reg  <= SLOT_COUNT;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                free_stack_reg[i] <= SLOT_IDX_W'(NUM_SLOTS - 1 - i);
            end
        end else begin
            slot_active_reg <= slot_active_next;
            free_count_reg  <= free_count_next;
            free_stack_reg  <= free_stack_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_address_reg <= slot_address_next;
        match_reg        <= match_next;
        res_number_reg   <= res_number_next;
        res_hit_reg      <= res_hit_next;
        res_err_reg      <= res_err_next;
        if (cmd.capture) begin
            req_op_reg   <= s_operation;
            req_addr_reg <= ADDR_WIDTH'(s_address);
            req_slot_reg <= s_slot;
        end
        if (cmd.publish) begin
            out_number_reg <= res_number_reg;
            out_hit_reg    <= res_hit_reg;
            out_err_reg    <= res_err_reg;
        end
    end

    assign m_slot_number = out_number_reg;
    assign m_hit         = out_hit_reg;
    assign m_error_code  = out_err_reg;

endmodule

>>> hw/rtl/address_breakpoint_pool_core.sv
// Address breakpoint pool: a set of breakpoint slots with a LIFO free list.
// Input channel (s_valid/s_ready) carries one request: add an address,
// free a slot, or scan a program counter against all active slots.
// Result channel (m_valid/m_ready) returns one result per request: the
// assigned slot number, the hit flag and an error code.
// Requests are handled one at a time. An add or free passes through the
// execute and done states, a scan through execute, reduce and done: the
// execute state compares every active slot in parallel and registers the
// match bits, the reduce state ORs them. The next request is accepted as
// soon as the result moves into the output register, so a new request is
// not taken before the last one is finished.
// If the receiver stalls, the finished result waits in the output register
// and one more request may be accepted and worked on; that request then
// holds until the output register is drained.
// Reset (aresetn low, synchronous) marks every slot inactive and refills the
// free list with slot 0 on top; no clearing pass is needed.
module address_breakpoint_pool_core
    import abp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [PADDR_W-1:0] s_address,
    input  logic [SLOT_W-1:0]  s_slot,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOT_W-1:0]  m_slot_number,
    output logic               m_hit,
    output logic [ERR_W-1:0]   m_error_code
);

    abp_cmd_t cmd;
    abp_sts_t sts;

    abp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    abp_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_operation   (s_operation),
        .s_address     (s_address),
        .s_slot        (s_slot),
        .m_slot_number (m_slot_number),
        .m_hit         (m_hit),
        .m_error_code  (m_error_code)
    );

endmodule

>>> hw/rtl/abp_checker.sv
`include "address_breakpoint_pool_core_macros.svh"

module abp_checker
    import abp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [OP_W-1:0]    s_operation,
    input logic [PADDR_W-1:0] s_address,
    input logic [SLOT_W-1:0]  s_slot,
    input logic               m_valid,
    input logic               m_ready,
    input logic [SLOT_W-1:0]  m_slot_number,
    input logic               m_hit,
    input logic [ERR_W-1:0]   m_error_code
);

    // A stalled result keeps its value.
    `ABP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_slot_number) && $stable(m_hit) && $stable(m_error_code), "result changed while stalled")

    // Requests are worked on one at a time.
    `ABP_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "request accepted while busy")

    // A hit comes only from a clean scan.
    `ABP_ASSERT_NOW(a_hit_clean, m_valid && m_hit, m_slot_number == '0 && m_error_code == ERR_OK, "hit with slot number or error")

    // A failed request reports nothing else.
    `ABP_ASSERT_NOW(a_err_clean, m_valid && m_error_code != ERR_OK, m_slot_number == '0 && !m_hit && (m_error_code == ERR_FULL || m_error_code == ERR_INACTIVE), "bad error result")

endmodule

bind address_breakpoint_pool_core abp_checker u_abp_checker (.*);
